@@ hdl/ffrpa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffrpa_pkg: shared types and constants for the frame roll/pitch stepper
// Payload structs, commands, sequencer states, CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ffrpa_pkg;

  localparam int VecWidthDef    = 16;
  localparam int PosWidthDef    = 32;
  localparam int CordicStepsDef = 14;
  localparam int SpeedWidth     = 32;
  localparam int AngWidth       = 16;
  // Q.20 angle plus head room
  localparam int ZWidth         = 24;
  // Q.30 cosine/sine plus head room
  localparam int CsWidth        = 33;
  localparam int TabLen         = 20;
  localparam logic signed [ZWidth-1:0] AngPi     = 24'sd3294199;
  localparam logic signed [ZWidth-1:0] AngHalfPi = 24'sd1647099;
  localparam logic signed [CsWidth-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [SpeedWidth-1:0] SpeedReset = -32'sd66;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ROLL  = 2'd1,
    CMD_PITCH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [AngWidth-1:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] head_x;
    logic signed [15:0] head_y;
    logic signed [15:0] head_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] wing_x;
    logic signed [15:0] wing_y;
    logic signed [15:0] wing_z;
  } out_item_t;

  function automatic logic signed [ZWidth-1:0] atan_q20(input logic [4:0] i);
    case (i)
      5'd0:  atan_q20 = 24'sd823550;
      5'd1:  atan_q20 = 24'sd486171;
      5'd2:  atan_q20 = 24'sd256879;
      5'd3:  atan_q20 = 24'sd130396;
      5'd4:  atan_q20 = 24'sd65451;
      5'd5:  atan_q20 = 24'sd32757;
      5'd6:  atan_q20 = 24'sd16383;
      5'd7:  atan_q20 = 24'sd8192;
      5'd8:  atan_q20 = 24'sd4096;
      5'd9:  atan_q20 = 24'sd2048;
      5'd10: atan_q20 = 24'sd1024;
      5'd11: atan_q20 = 24'sd512;
      5'd12: atan_q20 = 24'sd256;
      5'd13: atan_q20 = 24'sd128;
      5'd14: atan_q20 = 24'sd64;
      5'd15: atan_q20 = 24'sd32;
      5'd16: atan_q20 = 24'sd16;
      5'd17: atan_q20 = 24'sd8;
      5'd18: atan_q20 = 24'sd4;
      5'd19: atan_q20 = 24'sd2;
      default: atan_q20 = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/ffrpa_cordic.sv @@
// ----------------------------------------------------------------------------
// ffrpa_cordic: rotation-mode CORDIC, one iteration per cycle
// Takes a Q.20 angle, folds it into +-pi/2, returns cos and sin in Q.30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffrpa_cordic #(
  parameter int CORDIC_STEPS = ffrpa_pkg::CordicStepsDef
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic signed [ffrpa_pkg::ZWidth-1:0]   ang,
  output logic                                       done,
  output logic signed [ffrpa_pkg::CsWidth-1:0]       cos_q,
  output logic signed [ffrpa_pkg::CsWidth-1:0]       sin_q
);
  localparam int Steps = (CORDIC_STEPS > ffrpa_pkg::TabLen) ? ffrpa_pkg::TabLen
                                                           : CORDIC_STEPS;
  localparam int CntW  = $clog2(Steps + 1);

  logic signed [ffrpa_pkg::CsWidth-1:0] x_r, y_r;
  logic signed [ffrpa_pkg::ZWidth-1:0]  z_r;
  logic                                 neg_r, busy_r, done_r;
  logic [CntW-1:0]                      i_r;
  logic signed [ffrpa_pkg::CsWidth-1:0] xs, ys;
  logic signed [ffrpa_pkg::ZWidth-1:0]  z0;
  logic                                 neg0;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    neg0 = 1'b0;
    z0 = ang;
    if (ang > ffrpa_pkg::AngHalfPi) begin
      z0 = ang - ffrpa_pkg::AngPi;
      neg0 = 1'b1;
    end else if (ang < -ffrpa_pkg::AngHalfPi) begin
      z0 = ang + ffrpa_pkg::AngPi;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        x_r    <= ffrpa_pkg::CordicGain;
        y_r    <= '0;
        z_r    <= z0;
        neg_r  <= neg0;
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - ffrpa_pkg::atan_q20(5'(i_r));
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + ffrpa_pkg::atan_q20(5'(i_r));
        end
        if (i_r == CntW'(Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
    end
  end

  assign done  = done_r;
  assign cos_q = neg_r ? -x_r : x_r;
  assign sin_q = neg_r ? -y_r : y_r;

endmodule
`default_nettype wire

@@ hdl/ffrpa_sermul.sv @@
// ----------------------------------------------------------------------------
// ffrpa_sermul: bit-serial signed multiplier
// Shift-add over the multiplier bits, one bit a cycle, sign bit subtracted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffrpa_sermul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [AW-1:0]     a,
  input  wire logic signed [BW-1:0]     b,
  output logic                          done,
  output logic signed [AW+BW-1:0]       prod
);
  localparam int CntW = $clog2(BW + 1);

  logic signed [AW+BW-1:0] acc_r, mc_r;
  logic [BW-1:0]           mp_r;
  logic [CntW-1:0]         n_r;
  logic                    busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      n_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= '0;
        acc_r  <= '0;
        mc_r   <= (AW+BW)'(a);
        mp_r   <= b;
      end else if (busy_r) begin
        if (mp_r[0]) begin
          // top bit of a two's complement multiplier carries negative weight
          if (n_r == CntW'(BW - 1)) acc_r <= acc_r - mc_r;
          else                      acc_r <= acc_r + mc_r;
        end
        mc_r <= mc_r <<< 1;
        mp_r <= mp_r >> 1;
        n_r  <= n_r + 1'b1;
        if (n_r == CntW'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

@@ hdl/flight_frame_roll_pitch_advance.sv @@
// ----------------------------------------------------------------------------
// flight_frame_roll_pitch_advance: vehicle frame stepper
// Keeps position, heading, up and wing; applies tick, roll and pitch requests.
// ----------------------------------------------------------------------------
// Usage: a request (command, angle) is taken on in_valid with in_stall low.
// Each request gives exactly one result on out_valid: the frame after it.
// cfg_we/cfg_wdata write the Q16.16 speed; write only while idle.
// One request at a time: in_stall is high from acceptance until the result
// register is free again. All products go through one bit-serial multiplier
// (BW = 33 bits by default), one product at a time. Work from acceptance
// to out_valid:
//   tick          : 3 products
//   roll / pitch  : CORDIC, then 12 products
//   zero angle or unused command: straight to the result
// The next request is taken at the earliest at the edge that takes the result.
// Reset (rst_n low, synchronous) loads the initial frame and speed -66.
// While a result is shown and out_stall is high, the result holds and no new request is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module flight_frame_roll_pitch_advance #(
  parameter int CORDIC_STEPS = ffrpa_pkg::CordicStepsDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire ffrpa_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output ffrpa_pkg::out_item_t       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [31:0]           cfg_wdata
);
  localparam int VW = ffrpa_pkg::VecWidthDef;
  localparam int PW = ffrpa_pkg::PosWidthDef;
  localparam int F  = VW - 2;
  localparam int MW = ffrpa_pkg::CsWidth;
  localparam int PRW = 2 * MW;

  ffrpa_pkg::state_t st_r, st_nxt;
  logic signed [31:0] speed_r;
  logic signed [PW-1:0] pos_r [3];
  logic signed [VW-1:0] hd_r [3], up_r [3], wg_r [3];
  logic [1:0] cmd_r;
  logic [3:0] step_r;
  logic signed [PRW-1:0] acc_r;
  logic signed [MW-1:0] cs_c_r, cs_s_r;
  logic out_valid_r;

  logic cor_start, cor_done;
  logic signed [MW-1:0] cor_c, cor_s;
  logic mul_start, mul_done;
  logic signed [MW-1:0] ma, mb;
  logic signed [PRW-1:0] mprod;

  ffrpa_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cor_start),
    .ang({in_data.angle[15], in_data.angle, 7'b0}),
    .done(cor_done), .cos_q(cor_c), .sin_q(cor_s)
  );

  ffrpa_sermul #(.AW(MW), .BW(MW)) u_mul (
    .clk, .rst_n, .start(mul_start), .a(ma), .b(mb),
    .done(mul_done), .prod(mprod)
  );

  function automatic logic signed [VW-1:0] satv(input logic signed [PRW-1:0] v);
    if (v > PRW'(2 ** (VW - 1) - 1))   satv = VW'(2 ** (VW - 1) - 1);
    else if (v < -PRW'(2 ** (VW - 1))) satv = VW'(-(2 ** (VW - 1)));
    else                               satv = v[VW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] satp(input logic signed [PRW-1:0] v);
    if (v > PRW'(2 ** (PW - 1) - 1))   satp = {1'b0, {(PW-1){1'b1}}};
    else if (v < -PRW'(2 ** (PW - 1))) satp = {1'b1, {(PW-1){1'b0}}};
    else                               satp = v[PW-1:0];
  endfunction

  // Step plan.  Tick: steps 0..2 -> speed*head[k].
  // Rotate: steps 0..5 -> pairs (tgt[k]*c, up[k]*s), k = step/2.
  // Cross: steps 6..11 -> pairs (w1*h2, w2*h1) etc.
  logic signed [VW-1:0] tg [3];
  logic [1:0] kk;
  logic signed [VW-1:0] cp, cq;
  always_comb begin
    for (int k = 0; k < 3; k++) tg[k] = (cmd_r == ffrpa_pkg::CMD_ROLL) ? wg_r[k] : hd_r[k];
    // pair index, wrapping back to 0 for the cross steps
    kk = (step_r[3:1] >= 3'd3) ? 2'(step_r[3:1] - 3'd3) : step_r[2:1];
    cp = '0;
    cq = '0;
    case (step_r)
      4'd6:  begin cp = wg_r[1]; cq = hd_r[2]; end
      4'd7:  begin cp = wg_r[2]; cq = hd_r[1]; end
      4'd8:  begin cp = wg_r[2]; cq = hd_r[0]; end
      4'd9:  begin cp = wg_r[0]; cq = hd_r[2]; end
      4'd10: begin cp = wg_r[0]; cq = hd_r[1]; end
      4'd11: begin cp = wg_r[1]; cq = hd_r[0]; end
      default: begin cp = '0; cq = '0; end
    endcase
    if (cmd_r == ffrpa_pkg::CMD_TICK) begin
      ma = MW'(speed_r);
      mb = MW'(hd_r[step_r[1:0]]);
    end else if (step_r < 4'd6) begin
      ma = step_r[0] ? MW'(up_r[kk]) : MW'(tg[kk]);
      mb = step_r[0] ? cs_s_r : cs_c_r;
    end else begin
      ma = MW'(cp);
      mb = MW'(cq);
    end
  end

  logic last_step, accept, mul_go;
  logic signed [PRW-1:0] sum_nxt, pos_sum;
  always_comb begin
    st_nxt = st_r;
    cor_start = 1'b0;
    mul_go = 1'b0;
    accept = (st_r == ffrpa_pkg::ST_IDLE) && in_valid && !in_stall;
    last_step = (cmd_r == ffrpa_pkg::CMD_TICK) ? (step_r == 4'd2) : (step_r == 4'd11);
    // odd steps of rotate/cross subtract or add onto the pair's first product
    sum_nxt = (step_r >= 4'd6) ? acc_r - mprod : acc_r + mprod;
    pos_sum = PRW'(pos_r[step_r[1:0]]) + ((mprod + PRW'(2 ** (F - 1))) >>> F);
    case (st_r)
      ffrpa_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.command == ffrpa_pkg::CMD_TICK) begin
            st_nxt = ffrpa_pkg::ST_MUL;
            mul_go = 1'b1;
          end else if ((in_data.command == ffrpa_pkg::CMD_ROLL ||
                        in_data.command == ffrpa_pkg::CMD_PITCH) &&
                       in_data.angle != 16'sd0) begin
            st_nxt = ffrpa_pkg::ST_CORDIC;
            cor_start = 1'b1;
          end else begin
            st_nxt = ffrpa_pkg::ST_DONE;
          end
        end
      end
      ffrpa_pkg::ST_CORDIC: begin
        if (cor_done) begin
          st_nxt = ffrpa_pkg::ST_MUL;
          mul_go = 1'b1;
        end
      end
      ffrpa_pkg::ST_MUL: begin
        if (mul_done) begin
          if (last_step) st_nxt = ffrpa_pkg::ST_DONE;
          else           mul_go = 1'b1;
        end
      end
      ffrpa_pkg::ST_DONE: st_nxt = ffrpa_pkg::ST_IDLE;
      default: st_nxt = ffrpa_pkg::ST_IDLE;
    endcase
  end
  // operands come from step_r, so the multiply start is registered and goes out in the cycle after step_r updates
  logic mul_go_r;
  assign mul_start = mul_go_r;

  assign in_stall = (st_r != ffrpa_pkg::ST_IDLE) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ffrpa_pkg::ST_IDLE;
      speed_r <= ffrpa_pkg::SpeedReset;
      pos_r[0] <= '0; pos_r[1] <= '0; pos_r[2] <= PW'(6554);
      hd_r[0] <= -VW'(11471) <<< (F - 14);
      hd_r[1] <= -VW'(11471) <<< (F - 14);
      hd_r[2] <= -VW'(2294) <<< (F - 14);
      up_r[0] <= '0; up_r[1] <= '0; up_r[2] <= VW'(16384) <<< (F - 14);
      wg_r[0] <= -VW'(11585) <<< (F - 14);
      wg_r[1] <= VW'(11585) <<< (F - 14);
      wg_r[2] <= '0;
      out_valid_r <= 1'b0;
      mul_go_r <= 1'b0;
      step_r <= '0;
      cmd_r <= '0;
    end else begin
      st_r <= st_nxt;
      mul_go_r <= mul_go;
      if (cfg_we) speed_r <= $signed(cfg_wdata);
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (accept) begin
        cmd_r <= in_data.command;
        step_r <= '0;
      end
      if (cor_done) begin
        cs_c_r <= cor_c;
        cs_s_r <= cor_s;
      end
      if (st_r == ffrpa_pkg::ST_MUL && mul_done) begin
        if (cmd_r == ffrpa_pkg::CMD_TICK) begin
          pos_r[step_r[1:0]] <= satp(pos_sum);
        end else if (!step_r[0]) begin
          acc_r <= mprod;
        end else if (step_r < 4'd6) begin
          if (cmd_r == ffrpa_pkg::CMD_ROLL)
            wg_r[kk] <= satv((sum_nxt + PRW'(2 ** 29)) >>> 30);
          else
            hd_r[kk] <= satv((sum_nxt + PRW'(2 ** 29)) >>> 30);
        end else begin
          up_r[kk] <= satv((sum_nxt + PRW'(2 ** (F - 1))) >>> F);
        end
        step_r <= step_r + 1'b1;
      end
      if (st_r == ffrpa_pkg::ST_DONE) out_valid_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = '{pos_x: pos_r[0], pos_y: pos_r[1], pos_z: pos_r[2],
                      head_x: hd_r[0], head_y: hd_r[1], head_z: hd_r[2],
                      up_x: up_r[0], up_y: up_r[1], up_z: up_r[2],
                      wing_x: wg_r[0], wing_y: wg_r[1], wing_z: wg_r[2]};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ffrpa_pkg::ST_IDLE) |-> in_stall) else $error("request taken while busy");
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ffrpa_pkg::ST_DONE) |=> out_valid) else $error("result not raised");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 4'd12) else $error("step overrun");
  a_cordic_only_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cor_start |-> (in_data.command == ffrpa_pkg::CMD_ROLL ||
                   in_data.command == ffrpa_pkg::CMD_PITCH)) else $error("bad cordic start");

endmodule
`default_nettype wire
